// ----- rtl/hrl_pkg.sv -----
package hrl_pkg;

    localparam logic [7:0] MAX_LINE = 8'd254;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    localparam logic [7:0] RST_BASE_OFFSET = 8'h14;
    localparam logic [15:0] RST_REMAP_THRESHOLD = 16'h1000;
    localparam logic [7:0] RST_MAX_BYTE_COUNT = 8'd200;

    localparam logic [7:0] MAX_RECORD_TYPE = 8'd5;
    localparam logic [2:0] TYPE_DATA = 3'd0;
    localparam logic [2:0] TYPE_EOF = 3'd1;

    localparam logic [1:0] REG_BASE_OFFSET = 2'd0;
    localparam logic [1:0] REG_REMAP_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MAX_BYTE_COUNT = 2'd2;

    localparam logic [2:0] ERR_NO_COLON = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
    localparam logic [2:0] ERR_BAD_ADDRESS = 3'd2;
    localparam logic [2:0] ERR_BAD_TYPE = 3'd3;
    localparam logic [2:0] ERR_BAD_DATA = 3'd4;
    localparam logic [2:0] ERR_LINE_LONG = 3'd5;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_EOF    = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  line_position;
        logic [3:0]  high_nibble;
        logic [7:0]  record_count;
        logic [15:0] record_address;
        logic [2:0]  record_type;
        logic [7:0]  data_index;
        logic        eof_flag;
        logic        failed;
    } t_line_state;

    typedef struct packed {
        logic [7:0]  base_offset;
        logic [15:0] remap_threshold;
        logic [7:0]  max_byte_count;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [16:0] write_address;
        logic [7:0]  write_data;
        logic [2:0]  error_code;
        logic        eof_seen;
    } t_result;

    // bit 4 set for a non-hex character
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        case (c) inside
            [8'h30:8'h39]: r = {1'b0, 4'(c - 8'h30)};
            [8'h61:8'h66]: r = {1'b0, 4'(c - 8'h57)};
            [8'h41:8'h46]: r = {1'b0, 4'(c - 8'h37)};
            default:       r = 5'h10;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/hex_record_loader.sv -----
// channel  dir  handshake                 payload
// s        in   i_s_tvalid/o_s_tready     tdata text_char, tuser end_of_input
// m        out  o_m_tvalid/i_m_tready     tdata address/data/code/eof, tuser kind
// apb      in   psel/penable/pwrite       base_offset, remap_threshold, max_byte_count
//
// one character per cycle while the output register is empty or being drained: the
// parse step sits between the line state registers and the output word register,
// so a result shows in the cycle after its character is taken
// the input is taken whenever the output register is empty or being drained
// synchronous active-low reset clears line state and restores register defaults
module hex_record_loader
    import hrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_char
    input  logic        i_s_tuser,   // [0] end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [16:0] write_address, [24:17] write_data,
                                     // [27:25] error_code, [28] eof_seen
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_line_state r_state;
    t_line_state n_state;
    t_cfg        r_cfg;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        emit;
    logic        s_accept;

    hrl_parse u_parse (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_char         (i_s_tdata),
        .i_end_of_input (i_s_tuser),
        .o_state        (n_state),
        .o_emit         (emit),
        .o_result       (n_out)
    );

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state <= n_state;
            end
            if (s_accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser = r_out.kind;
    assign o_m_tdata = {3'd0, r_out.eof_seen, r_out.error_code,
                        r_out.write_data, r_out.write_address};

    // config registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_offset <= RST_BASE_OFFSET;
            r_cfg.remap_threshold <= RST_REMAP_THRESHOLD;
            r_cfg.max_byte_count <= RST_MAX_BYTE_COUNT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_BASE_OFFSET:     r_cfg.base_offset <= pwdata[7:0];
                REG_REMAP_THRESHOLD: r_cfg.remap_threshold <= pwdata[15:0];
                REG_MAX_BYTE_COUNT:  r_cfg.max_byte_count <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE_OFFSET:     prdata = {24'd0, r_cfg.base_offset};
            REG_REMAP_THRESHOLD: prdata = {16'd0, r_cfg.remap_threshold};
            REG_MAX_BYTE_COUNT:  prdata = {24'd0, r_cfg.max_byte_count};
            default:             prdata = '0;
        endcase
    end

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.failed |=> r_state.failed)
        else $error("failed flag dropped");

    a_error_word_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_ERROR |-> r_state.failed)
        else $error("error word without failed state");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_position <= MAX_LINE)
        else $error("line position beyond limit");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.data_index <= r_state.record_count)
        else $error("data index beyond byte count");

    a_silent_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.failed && !r_out_valid |=> !r_out_valid)
        else $error("word after failure");

endmodule

// ----- rtl/hrl_parse.sv -----
module hrl_parse
    import hrl_pkg::*;
(
    input  t_line_state i_state,
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_char,
    input  logic        i_end_of_input,
    output t_line_state o_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic [7:0]  lp;
    logic [4:0]  hex;
    logic [7:0]  pair;
    logic        inc_valid;
    logic [2:0]  inc_code;
    logic [2:0]  field_code;
    t_line_state n;
    t_result     res;
    logic        emit;

    assign lp = i_state.line_position;
    assign hex = hex_decode(i_char);
    assign pair = {i_state.high_nibble, hex[3:0]};

    // error for a line that ends now
    always_comb begin
        inc_valid = 1'b1;
        inc_code = ERR_NO_COLON;
        if (lp == 8'd0) begin
            inc_code = ERR_NO_COLON;
        end else if (lp < 8'd3) begin
            inc_code = ERR_BAD_COUNT;
        end else if (lp < 8'd7) begin
            inc_code = ERR_BAD_ADDRESS;
        end else if (lp < 8'd9) begin
            inc_code = ERR_BAD_TYPE;
        end else if (i_state.record_type == TYPE_DATA
                     && i_state.data_index < i_state.record_count) begin
            inc_code = ERR_BAD_DATA;
        end else begin
            inc_valid = 1'b0;
        end
    end

    assign field_code = (lp < 8'd3) ? ERR_BAD_COUNT :
                        (lp < 8'd7) ? ERR_BAD_ADDRESS : ERR_BAD_TYPE;

    always_comb begin
        n = i_state;
        emit = 1'b0;
        res.kind = KIND_WRITE;
        res.write_address = '0;
        res.write_data = '0;
        res.error_code = '0;
        if (!i_state.failed) begin
            if (i_end_of_input || i_char == CHAR_NEWLINE) begin
                if (inc_valid && (!i_end_of_input || lp != 8'd0)) begin
                    n.failed = 1'b1;
                    emit = 1'b1;
                    res.kind = KIND_ERROR;
                    res.error_code = inc_code;
                end else begin
                    n.line_position = '0;
                    n.high_nibble = '0;
                    n.record_count = '0;
                    n.record_address = '0;
                    n.record_type = '0;
                    n.data_index = '0;
                    if (i_end_of_input) begin
                        emit = 1'b1;
                        res.kind = KIND_STATUS;
                    end
                end
            end else if (lp >= MAX_LINE) begin
                n.failed = 1'b1;
                emit = 1'b1;
                res.kind = KIND_ERROR;
                res.error_code = ERR_LINE_LONG;
            end else begin
                n.line_position = 8'(lp + 8'd1);
                if (lp == 8'd0) begin
                    if (i_char != CHAR_COLON) begin
                        n.failed = 1'b1;
                        emit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_NO_COLON;
                    end
                end else if (lp <= 8'd8) begin
                    if (hex[4]) begin
                        n.failed = 1'b1;
                        emit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = field_code;
                    end else if (lp >= 8'd3 && lp <= 8'd6) begin
                        n.record_address = {i_state.record_address[11:0], hex[3:0]};
                    end else if (lp[0]) begin
                        n.high_nibble = hex[3:0];
                    end else if (lp == 8'd2) begin
                        if (pair > i_cfg.max_byte_count) begin
                            n.failed = 1'b1;
                            emit = 1'b1;
                            res.kind = KIND_ERROR;
                            res.error_code = ERR_BAD_COUNT;
                        end else begin
                            n.record_count = pair;
                        end
                    end else if (pair > MAX_RECORD_TYPE) begin
                        n.failed = 1'b1;
                        emit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_BAD_TYPE;
                    end else begin
                        n.record_type = pair[2:0];
                        // remap once per record
                        if (pair[2:0] == TYPE_DATA
                            && i_state.record_address > i_cfg.remap_threshold) begin
                            n.record_address = i_state.record_address
                                               - i_cfg.remap_threshold;
                        end
                        if (pair[2:0] == TYPE_EOF) begin
                            n.eof_flag = 1'b1;
                            emit = 1'b1;
                            res.kind = KIND_EOF;
                        end
                    end
                end else if (i_state.record_type == TYPE_DATA
                             && i_state.data_index < i_state.record_count) begin
                    if (hex[4]) begin
                        n.failed = 1'b1;
                        emit = 1'b1;
                        res.kind = KIND_ERROR;
                        res.error_code = ERR_BAD_DATA;
                    end else if (lp[0]) begin
                        n.high_nibble = hex[3:0];
                    end else begin
                        n.data_index = 8'(i_state.data_index + 8'd1);
                        emit = 1'b1;
                        res.kind = KIND_WRITE;
                        res.write_data = pair;
                        res.write_address = {1'b0, i_state.record_address}
                                            + {9'd0, i_cfg.base_offset}
                                            + {9'd0, i_state.data_index};
                    end
                end
            end
        end
        res.eof_seen = n.eof_flag;
    end

    assign o_state = n;
    assign o_emit = emit;
    assign o_result = res;

endmodule
